// File: src/dcre_pkg.sv
// dcre_pkg: shared types, widths and constant tables for the depth column ray extractor
// no dependencies
package dcre_pkg;

  localparam int ROWS_PER_COLUMN = 8;
  localparam int MM_W            = 16;
  localparam int KEY_W           = MM_W + 1;
  localparam int LANE_W          = $clog2(ROWS_PER_COLUMN);
  localparam int CNT_W           = $clog2(ROWS_PER_COLUMN + 1);
  localparam int SENSOR_W        = 2;
  localparam int COLUMN_W        = 3;
  localparam int HEAD_W          = 14;
  localparam int BEAR_W          = 15;
  localparam int CFG_IDX_W       = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_MARGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT   = 2'd3;

  localparam logic [MM_W-1:0] MIN_VALID_RST   = 16'd100;
  localparam logic [MM_W-1:0] MAX_VALID_RST   = 16'd4000;
  localparam logic [MM_W-1:0] FREE_MARGIN_RST = 16'd80;
  localparam logic [MM_W-1:0] HIT_LIMIT_RST   = 16'd3500;

  // sort key: msb set for a reading outside the window so it ranks last
  typedef logic [KEY_W-1:0]                     key_t;
  typedef key_t [ROWS_PER_COLUMN-1:0]           key_vec_t;
  typedef logic [LANE_W-1:0]                    rank_t;
  typedef rank_t [ROWS_PER_COLUMN-1:0]          rank_vec_t;
  typedef logic [CNT_W-1:0]                     cnt_t;

  // pipeline load enables
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } dcre_ctrl_t;

  // sensor facing base angle in sixteenths of a degree
  function automatic logic signed [BEAR_W-1:0] sensor_base(input logic [SENSOR_W-1:0] s);
    logic signed [BEAR_W-1:0] b;
    case (s)
      2'd0:    b = 15'sd0;
      2'd1:    b = 15'sd1440;
      2'd2:    b = 15'sd2880;
      2'd3:    b = -15'sd1440;
      default: b = 15'sd0;
    endcase
    return b;
  endfunction

  // centre of column c across a 45 degree field of view: (2c - 7) * 45
  function automatic logic signed [BEAR_W-1:0] column_offset(input logic [COLUMN_W-1:0] c);
    logic signed [BEAR_W-1:0] o;
    case (c)
      3'd0:    o = -15'sd315;
      3'd1:    o = -15'sd225;
      3'd2:    o = -15'sd135;
      3'd3:    o = -15'sd45;
      3'd4:    o = 15'sd45;
      3'd5:    o = 15'sd135;
      3'd6:    o = 15'sd225;
      3'd7:    o = 15'sd315;
      default: o = 15'sd0;
    endcase
    return o;
  endfunction

endpackage

// File: src/dcre_lane.sv
// dcre_lane: one row lane, window gate then rank of its reading among all rows
// depends on dcre_pkg
module dcre_lane (
  input  logic                        clk,
  input  dcre_pkg::dcre_ctrl_t        ctrl,
  input  logic [dcre_pkg::LANE_W-1:0] lane_id,
  input  logic [dcre_pkg::MM_W-1:0]   reading,
  input  logic [dcre_pkg::MM_W-1:0]   min_valid_mm,
  input  logic [dcre_pkg::MM_W-1:0]   max_valid_mm,
  input  dcre_pkg::key_vec_t          keys_s1,
  output dcre_pkg::key_t              key_s1_r,
  output dcre_pkg::key_t              key_s2_r,
  output dcre_pkg::rank_t             rank_r
);
  import dcre_pkg::*;

  logic                       in_window;
  logic [ROWS_PER_COLUMN-1:0] below;
  rank_t                      rank_nxt;

  assign in_window = (reading >= min_valid_mm) && (reading <= max_valid_mm);

  // lower rows win ties so the ranks form a permutation
  always_comb begin
    for (int j = 0; j < ROWS_PER_COLUMN; j++) begin
      below[j] = (keys_s1[j] < key_s1_r) ||
                 ((keys_s1[j] == key_s1_r) && (LANE_W'(j) < lane_id));
    end
    rank_nxt = LANE_W'($countones(below));
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      key_s1_r <= {~in_window, reading};
    end
    if (ctrl.ld2) begin
      key_s2_r <= key_s1_r;
      rank_r   <= rank_nxt;
    end
  end

endmodule

// File: src/dcre_merge.sv
// dcre_merge: picks the lane ranked at count/2 and forms span, hit and output registers
// depends on dcre_pkg
module dcre_merge (
  input  logic                               clk,
  input  dcre_pkg::dcre_ctrl_t               ctrl,
  input  dcre_pkg::key_vec_t                 keys_s2,
  input  dcre_pkg::rank_vec_t                ranks_s2,
  input  dcre_pkg::cnt_t                     count_s2,
  input  logic signed [dcre_pkg::BEAR_W-1:0] bearing_s2,
  input  logic [dcre_pkg::MM_W-1:0]          free_margin_mm,
  input  logic [dcre_pkg::MM_W-1:0]          hit_limit_mm,
  output logic [dcre_pkg::MM_W-1:0]          range_mm_r,
  output logic                               range_valid_r,
  output logic [dcre_pkg::MM_W-1:0]          free_span_mm_r,
  output logic                               obstacle_hit_r,
  output logic signed [dcre_pkg::BEAR_W-1:0] bearing_r
);
  import dcre_pkg::*;

  rank_t           sel;
  logic [MM_W-1:0] median;
  logic            any_kept;
  logic [MM_W-1:0] span;

  assign sel      = LANE_W'(count_s2 >> 1);
  assign any_kept = (count_s2 != '0);

  // ranks are a permutation, so exactly one lane matches
  always_comb begin
    median = '0;
    for (int i = 0; i < ROWS_PER_COLUMN; i++) begin
      if (ranks_s2[i] == sel) begin
        median = median | keys_s2[i][MM_W-1:0];
      end
    end
    if (!any_kept) begin
      median = '0;
    end
    span = (median > free_margin_mm) ? (median - free_margin_mm) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      range_mm_r     <= median;
      range_valid_r  <= any_kept;
      free_span_mm_r <= span;
      obstacle_hit_r <= any_kept && (median <= hit_limit_mm);
      bearing_r      <= bearing_s2;
    end
  end

endmodule

// File: src/depth_column_ray_extractor_top.sv
// one column per cycle sustained while out_stall is low
// an input request passes three stages to the result request: gate, rank compare, merge select
// a stall on the result side backs up stage by stage; bubbles between stages are squeezed out
// reset (rst_n low, synchronous) empties the pipeline and loads the window, margin and hit limit
// defaults of 100, 4000, 80 and 3500 mm; payload registers are not reset
// depends on dcre_pkg, dcre_lane, dcre_merge
module depth_column_ray_extractor_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input column requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_0,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_1,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_2,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_3,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_4,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_5,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_6,
  input  logic [dcre_pkg::MM_W-1:0]           in_reading_7,
  input  logic [dcre_pkg::SENSOR_W-1:0]       in_sensor_index,
  input  logic [dcre_pkg::COLUMN_W-1:0]       in_column_index,
  input  logic signed [dcre_pkg::HEAD_W-1:0]  in_heading_sixteenths,
  // result requests
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dcre_pkg::MM_W-1:0]           out_range_mm,
  output logic                                out_range_valid,
  output logic [dcre_pkg::MM_W-1:0]           out_free_span_mm,
  output logic                                out_obstacle_hit,
  output logic signed [dcre_pkg::BEAR_W-1:0]  out_bearing_sixteenths,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcre_pkg::MM_W-1:0]           cfg_data
);
  import dcre_pkg::*;

  // configuration registers
  logic [MM_W-1:0] min_valid_r,   min_valid_nxt;
  logic [MM_W-1:0] max_valid_r,   max_valid_nxt;
  logic [MM_W-1:0] free_margin_r, free_margin_nxt;
  logic [MM_W-1:0] hit_limit_r,   hit_limit_nxt;

  // stage occupancy
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;

  dcre_ctrl_t ctrl;

  logic [MM_W-1:0] readings [ROWS_PER_COLUMN];

  key_vec_t  keys_s1;
  key_vec_t  keys_s2;
  rank_vec_t ranks_s2;

  cnt_t count_r;
  logic signed [BEAR_W-1:0] bearing_s1_r;
  logic signed [BEAR_W-1:0] bearing_s2_r;
  logic signed [BEAR_W-1:0] bearing_in;

  // msb of each key marks a reading outside the window
  function automatic logic [ROWS_PER_COLUMN-1:0] keys_of_msb(input key_vec_t k);
    logic [ROWS_PER_COLUMN-1:0] m;
    for (int i = 0; i < ROWS_PER_COLUMN; i++) begin
      m[i] = k[i][KEY_W-1];
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port: always ready, written registers are used live; the user must make writes
  // come only while the pipeline is empty, as the block itself does not check that it is empty
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    min_valid_nxt   = min_valid_r;
    max_valid_nxt   = max_valid_r;
    free_margin_nxt = free_margin_r;
    hit_limit_nxt   = hit_limit_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_VALID:   min_valid_nxt   = cfg_data;
        CFG_MAX_VALID:   max_valid_nxt   = cfg_data;
        CFG_FREE_MARGIN: free_margin_nxt = cfg_data;
        CFG_HIT_LIMIT:   hit_limit_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its contents move on
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl.ld3 = v2_r && (!v3_r || !out_stall);
    ctrl.ld2 = v1_r && (!v2_r || ctrl.ld3);
    ctrl.ld1 = in_valid && (!v1_r || ctrl.ld2);
    v3_nxt   = ctrl.ld3 || (v3_r && out_stall);
    v2_nxt   = ctrl.ld2 || (v2_r && !ctrl.ld3);
    v1_nxt   = ctrl.ld1 || (v1_r && !ctrl.ld2);
  end

  assign in_stall  = v1_r && !ctrl.ld2;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      min_valid_r   <= MIN_VALID_RST;
      max_valid_r   <= MAX_VALID_RST;
      free_margin_r <= FREE_MARGIN_RST;
      hit_limit_r   <= HIT_LIMIT_RST;
    end else begin
      v1_r          <= v1_nxt;
      v2_r          <= v2_nxt;
      v3_r          <= v3_nxt;
      min_valid_r   <= min_valid_nxt;
      max_valid_r   <= max_valid_nxt;
      free_margin_r <= free_margin_nxt;
      hit_limit_r   <= hit_limit_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // bearing: heading plus sensor base plus column centre, no wrap
  // ---------------------------------------------------------------------------
  assign bearing_in = BEAR_W'(in_heading_sixteenths) + sensor_base(in_sensor_index)
                      + column_offset(in_column_index);

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      bearing_s1_r <= bearing_in;
    end
    if (ctrl.ld2) begin
      bearing_s2_r <= bearing_s1_r;
      count_r      <= CNT_W'($countones(~keys_of_msb(keys_s1)));
    end
  end

  // ---------------------------------------------------------------------------
  // row lanes: gate in stage one, rank among all rows in stage two
  // ---------------------------------------------------------------------------
  assign readings[0] = in_reading_0;
  assign readings[1] = in_reading_1;
  assign readings[2] = in_reading_2;
  assign readings[3] = in_reading_3;
  assign readings[4] = in_reading_4;
  assign readings[5] = in_reading_5;
  assign readings[6] = in_reading_6;
  assign readings[7] = in_reading_7;

  for (genvar g = 0; g < ROWS_PER_COLUMN; g++) begin : g_lane
    dcre_lane u_lane (
      .clk          (clk),
      .ctrl         (ctrl),
      .lane_id      (LANE_W'(g)),
      .reading      (readings[g]),
      .min_valid_mm (min_valid_r),
      .max_valid_mm (max_valid_r),
      .keys_s1      (keys_s1),
      .key_s1_r     (keys_s1[g]),
      .key_s2_r     (keys_s2[g]),
      .rank_r       (ranks_s2[g])
    );
  end

  // ---------------------------------------------------------------------------
  // merge: median select, free span, hit flag, result register
  // ---------------------------------------------------------------------------
  dcre_merge u_merge (
    .clk            (clk),
    .ctrl           (ctrl),
    .keys_s2        (keys_s2),
    .ranks_s2       (ranks_s2),
    .count_s2       (count_r),
    .bearing_s2     (bearing_s2_r),
    .free_margin_mm (free_margin_r),
    .hit_limit_mm   (hit_limit_r),
    .range_mm_r     (out_range_mm),
    .range_valid_r  (out_range_valid),
    .free_span_mm_r (out_free_span_mm),
    .obstacle_hit_r (out_obstacle_hit),
    .bearing_r      (out_bearing_sixteenths)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_hit_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_obstacle_hit) |-> out_range_valid)
    else $error("obstacle flagged with no kept reading");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_valid) |-> (out_range_mm == '0 && out_free_span_mm == '0))
    else $error("range or span non-zero with no kept reading");

  a_span_le_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_span_mm <= out_range_mm))
    else $error("free span exceeds range");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !v3_r) |=> v3_r)
    else $error("stage two item not moved into an empty result register");

endmodule
